>>> hdl/cas_pkg.sv
// shared types, character codes and helpers for the cigar alignment span block
`timescale 1ns / 1ps

package cas_pkg;

  localparam int MAX_DIGITS_DEF = 5;
  localparam int CMD_DEPTH_DEF  = 4;
  localparam int SPAN_DEPTH_DEF = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4E;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_MATCH = 3'd1,
    OP_CLIP  = 3'd2,
    OP_INS   = 3'd3,
    OP_DEL   = 3'd4
  } op_t;

  typedef struct packed {
    logic [7:0]         cigar_char;
    logic               last_char;
    logic signed [31:0] ref_start;
    logic               fwd_strand;
    logic [19:0]        read_length;
  } cigar_item_t;

  typedef struct packed {
    logic signed [31:0] read_first;
    logic signed [31:0] read_final;
    logic signed [31:0] ref_first;
    logic signed [31:0] ref_final;
  } span_item_t;

  // control part of one command passed from front to back
  typedef struct packed {
    op_t         op;
    logic        last;
    logic [31:0] ref_start;
    logic        fwd_strand;
    logic [19:0] read_length;
  } cmd_ctl_t;

  // bits needed for a run length of up to n decimal digits
  function automatic int pend_width(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return $clog2(p);
  endfunction

  function automatic op_t classify(input logic [7:0] ch);
    op_t op;
    case (ch)
      CH_M, CH_EQ, CH_X: op = OP_MATCH;
      CH_S, CH_H:        op = OP_CLIP;
      CH_I:              op = OP_INS;
      CH_D, CH_N:        op = OP_DEL;
      default:           op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

>>> hdl/cas_fifo.sv
// small register queue with first-word fall-through read
`timescale 1ns / 1ps

module cas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/cas_front.sv
// front end: takes characters, builds run lengths, issues operation commands
`timescale 1ns / 1ps

module cas_front import cas_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int PEND_W     = pend_width(MAX_DIGITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cigar_item_t       cigar,
  output logic              cmd_push,
  input  logic              cmd_full,
  output cmd_ctl_t          cmd_ctl,
  output logic [PEND_W-1:0] cmd_len
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;
  logic [CNT_W-1:0]  digit_count;
  logic              accept;
  logic              is_digit;
  logic [3:0]        digit;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign is_digit = (cigar.cigar_char >= CH_ZERO) && (cigar.cigar_char <= CH_NINE);
  assign digit    = 4'(cigar.cigar_char - CH_ZERO);

  // times ten as two shifts and an add
  assign pending_next = (pending << 3) + (pending << 1) + PEND_W'(digit);

  // a digit only goes to the back end when it closes the string
  assign cmd_push = accept && (!is_digit || cigar.last_char);

  always_comb begin
    cmd_ctl.op          = is_digit ? OP_NONE : classify(cigar.cigar_char);
    cmd_ctl.last        = cigar.last_char;
    cmd_ctl.ref_start   = cigar.ref_start;
    cmd_ctl.fwd_strand  = cigar.fwd_strand;
    cmd_ctl.read_length = cigar.read_length;
  end

  assign cmd_len = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      digit_count <= '0;
    end else if (accept) begin
      if (!is_digit || cigar.last_char) begin
        pending     <= '0;
        digit_count <= '0;
      end else if (digit_count < CNT_W'(MAX_DIGITS)) begin
        pending     <= pending_next;
        digit_count <= digit_count + CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/cas_back.sv
// back end: applies commands to the span accumulators and forms the result
`timescale 1ns / 1ps

module cas_back import cas_pkg::*; #(
  parameter int PEND_W = pend_width(MAX_DIGITS_DEF)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_ctl_t          cmd_ctl,
  input  logic [PEND_W-1:0] cmd_len,
  output logic              cmd_pop,
  output logic              span_push,
  input  logic              span_full,
  output span_item_t        span
);

  logic [31:0] read_left;
  logic [31:0] read_right;
  logic [31:0] ref_advance;
  logic        match_seen;

  logic [31:0] read_left_next;
  logic [31:0] read_right_next;
  logic [31:0] ref_advance_next;
  logic        match_seen_next;
  logic [31:0] len;

  // finish stage: final sums held while the mirrored result is formed
  logic        fin_valid;
  logic [31:0] fin_left;
  logic [31:0] fin_right;
  logic [31:0] fin_advance;
  logic [31:0] fin_ref_start;
  logic        fin_same;
  logic [19:0] fin_read_length;
  logic        fin_ready;
  logic        take;

  assign len       = 32'(cmd_len);
  assign fin_ready = !fin_valid || !span_full;
  assign take      = cmd_valid && (!cmd_ctl.last || fin_ready);
  assign cmd_pop   = take;
  assign span_push = fin_valid && !span_full;

  always_comb begin
    read_left_next   = read_left;
    read_right_next  = read_right;
    ref_advance_next = ref_advance;
    match_seen_next  = match_seen;
    case (cmd_ctl.op)
      OP_MATCH: begin
        read_right_next  = read_right + len;
        ref_advance_next = ref_advance + len;
        match_seen_next  = 1'b1;
      end
      OP_CLIP: begin
        if (!match_seen) begin
          read_left_next  = read_left + len;
          read_right_next = read_right + len;
        end
      end
      OP_INS: begin
        read_right_next = read_right + len;
      end
      OP_DEL: begin
        // deletion and skip advance by one less than the run length
        ref_advance_next = ref_advance + len - 32'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_left   <= '0;
      read_right  <= '1;
      ref_advance <= '0;
      match_seen  <= 1'b0;
    end else if (take) begin
      if (cmd_ctl.last) begin
        read_left   <= '0;
        read_right  <= '1;
        ref_advance <= '0;
        match_seen  <= 1'b0;
      end else begin
        read_left   <= read_left_next;
        read_right  <= read_right_next;
        ref_advance <= ref_advance_next;
        match_seen  <= match_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (take && cmd_ctl.last) begin
      fin_valid <= 1'b1;
    end else if (span_push) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd_ctl.last) begin
      fin_left        <= read_left_next;
      fin_right       <= read_right_next;
      fin_advance     <= ref_advance_next;
      fin_ref_start   <= cmd_ctl.ref_start;
      fin_same        <= cmd_ctl.fwd_strand;
      fin_read_length <= cmd_ctl.read_length;
    end
  end

  // opposite strand mirrors read positions against the read length
  always_comb begin
    if (fin_same) begin
      span.read_first = fin_left;
      span.read_final = fin_right;
    end else begin
      span.read_first = 32'(fin_read_length) - fin_right - 32'd1;
      span.read_final = 32'(fin_read_length) - fin_left - 32'd1;
    end
    span.ref_first = fin_ref_start;
    span.ref_final = fin_ref_start - 32'd1 + fin_advance;
  end

endmodule

>>> hdl/cigar_alignment_span.sv
// top level of the cigar alignment span block
`timescale 1ns / 1ps

// Streams a CIGAR string one character per item and, on the item flagged
// last_char, queues one result with the read and reference spans (read
// positions mirrored against read_length when fwd_strand is 0). A new
// character is taken every cycle as long as full is low; each character is
// handled by the digit/run-length front end and, if it is an operation or
// the last one, by the span accumulators behind a command queue of
// CMD_DEPTH entries. A result passes from its last character through the
// command queue and the finish register into a SPAN_DEPTH queue, where it
// waits until popped; a stalled result queue backs up into full. After
// each result the block starts a fresh string with the next character.

module cigar_alignment_span import cas_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
  parameter int SPAN_DEPTH = SPAN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  cigar_item_t cigar,
  output logic        empty,
  input  logic        pop,
  output span_item_t  span
);

  localparam int PEND_W = pend_width(MAX_DIGITS);
  localparam int CMD_W  = $bits(cmd_ctl_t) + PEND_W;
  localparam int SPAN_W = $bits(span_item_t);

  logic              cmd_push;
  logic              cmd_full;
  cmd_ctl_t          front_ctl;
  logic [PEND_W-1:0] front_len;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CMD_W-1:0]  cmd_rdata;
  cmd_ctl_t          back_ctl;
  logic [PEND_W-1:0] back_len;
  logic              span_push;
  logic              span_full;
  span_item_t        back_span;
  logic [SPAN_W-1:0] span_rdata;

  cas_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .PEND_W     (PEND_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cigar    (cigar),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd_ctl  (front_ctl),
    .cmd_len  (front_len)
  );

  cas_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .wdata ({front_ctl, front_len}),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_rdata)
  );

  assign back_ctl = cmd_ctl_t'(cmd_rdata[CMD_W-1:PEND_W]);
  assign back_len = cmd_rdata[PEND_W-1:0];

  cas_back #(
    .PEND_W (PEND_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd_ctl   (back_ctl),
    .cmd_len   (back_len),
    .cmd_pop   (cmd_pop),
    .span_push (span_push),
    .span_full (span_full),
    .span      (back_span)
  );

  cas_fifo #(
    .WIDTH (SPAN_W),
    .DEPTH (SPAN_DEPTH)
  ) u_span_q (
    .clk   (clk),
    .rst   (rst),
    .push  (span_push),
    .full  (span_full),
    .wdata (back_span),
    .pop   (pop),
    .empty (empty),
    .rdata (span_rdata)
  );

  assign span = span_item_t'(span_rdata);

endmodule

>>> hdl/cas_checker.sv
// port-level checks for the cigar alignment span block, bound to the top level
`timescale 1ns / 1ps

module cas_checker import cas_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input span_item_t  span
);

  // reset drops every queued result
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves room for a new character
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("block full after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished without pop");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(span))
    else $error("waiting result changed without pop");

  // a waiting result carries no unknown bits
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown(span))
    else $error("waiting result has unknown bits");

endmodule

bind cigar_alignment_span cas_checker u_cas_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .span  (span)
);
